// ===== design/keyframe_track_sampler_unit_defines.svh =====
// Assertion macros for the keyframe track sampler.
// Included by the top level; no other dependencies.
`ifndef KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define KTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/kts_pkg.sv =====
// Types, codes and controller/datapath interface of the keyframe track sampler.
// No dependencies.
package kts_pkg;

    typedef struct packed {
        logic               mode;
        logic [5:0]         key_index;
        logic [16:0]        key_percent;
        logic [16:0]        query_percent;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [5:0]         lower_key;
        logic [1:0]         status;
    } t_out_item;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_CLAMP  = 2'd2;
    localparam logic [1:0] ST_ZERO_W = 2'd3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic CFG_KEY_COUNT  = 1'b0;
    localparam logic CFG_VALUE_KIND = 1'b1;

    localparam logic [16:0] PCT_ONE = 17'h10000;

    localparam int          ITER_W       = 6;
    localparam logic [5:0]  F_DIV_LAST   = 6'd16;
    localparam logic [5:0]  SQRT_LAST    = 6'd31;
    localparam logic [1:0]  COMP_Z       = 2'd2;
    localparam logic [1:0]  COMP_W       = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_FIRST, S_RD_LAST, S_CLASSIFY, S_SRCH, S_SRCH_WAIT,
        S_RD_PL, S_RD_PH, S_WIDTH, S_FDIV, S_F_DONE, S_VRD_LO, S_VRD_HI,
        S_VCAP, S_MUL, S_ADD, S_MAG, S_SHIFT, S_SQ, S_ACC, S_SQRT_INIT,
        S_SQRT, S_NDIV_LOAD, S_NDIV, S_NDIV_DONE, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_RD_FIRST, OP_RD_LAST, OP_CLASSIFY, OP_SRCH_RD,
        OP_SRCH_UPD, OP_RD_PL, OP_RD_PH, OP_WIDTH, OP_DIV_STEP, OP_F_DONE,
        OP_VRD_LO, OP_VRD_HI, OP_VCAP, OP_MUL, OP_ADD, OP_MAG, OP_SHIFT,
        OP_SQ, OP_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_NDIV_LOAD,
        OP_NDIV_DONE, OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] comp;
    } t_dp_cmd;

    typedef struct packed {
        logic value_kind;
        logic below_first;
        logic above_last;
        logic search_more;
        logic zero_width;
        logic mag_zero;
        logic mag_norm;
    } t_dp_status;

endpackage

// ===== design/keyframe_track_sampler_unit.sv =====
// Keyframe track sampler, one item at a time. A vector sample is clamped, or in range takes
// up to six search steps and then the fraction divide unless the interval has zero width.
// Quaternion adds up to 29 normalising shifts, a 32-step square root and four divides.
// The result goes valid as the input becomes ready again and may wait there; an output
// stall holds the next item in the output state. Synchronous active-low reset; key
// tables not cleared.
`include "keyframe_track_sampler_unit_defines.svh"
module keyframe_track_sampler_unit #(
    parameter int MAX_KEYS        = 64,
    parameter int VALUE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kts_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kts_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    logic [6:0]          r_keyframe_count;
    logic                r_value_kind;
    kts_pkg::t_dp_cmd    cmd;
    kts_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyframe_count <= 7'd2;
            r_value_kind     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kts_pkg::CFG_KEY_COUNT:  r_keyframe_count <= i_cfg_data;
                kts_pkg::CFG_VALUE_KIND: r_value_kind     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    kts_ctrl #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    kts_datapath #(.MAX_KEYS(MAX_KEYS), .VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_in_data        (i_in_data),
        .i_keyframe_count (r_keyframe_count),
        .i_value_kind     (r_value_kind),
        .o_status         (status),
        .o_out_data       (o_out_data)
    );

    `KTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `KTS_ASSERT_IMPL(a_load_result_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == kts_pkg::ST_LOAD), (o_out_data.out_x == 32'sd0) && (o_out_data.lower_key == 6'd0))
    `KTS_ASSERT_IMPL(a_vector_w_zero, i_clk, i_rst_n, o_out_valid && !r_value_kind, o_out_data.out_w == 32'sd0)
endmodule

// ===== design/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/kts_ctrl.sv =====
// Sequencing state machine of the keyframe track sampler.
// Depends on kts_pkg.
module kts_ctrl #(
    parameter int VALUE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_mode,
    input  logic                i_out_ready,
    input  kts_pkg::t_dp_status i_status,
    output kts_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);
    kts_pkg::t_state               r_state, n_state;
    logic [kts_pkg::ITER_W-1:0]    r_cnt, n_cnt;
    logic [1:0]                    r_comp, n_comp;
    logic                          r_out_valid;
    logic                          out_free;
    logic [1:0]                    last_comp;

    assign out_free  = !r_out_valid || i_out_ready;
    assign last_comp = i_status.value_kind ? kts_pkg::COMP_W : kts_pkg::COMP_Z;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        case (r_state)
            kts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode == kts_pkg::MODE_LOAD) ? kts_pkg::S_OUT
                                                                : kts_pkg::S_RD_FIRST;
                end
            end
            kts_pkg::S_RD_FIRST: n_state = kts_pkg::S_RD_LAST;
            kts_pkg::S_RD_LAST:  n_state = kts_pkg::S_CLASSIFY;
            kts_pkg::S_CLASSIFY: begin
                n_state = (i_status.below_first || i_status.above_last)
                          ? kts_pkg::S_VRD_LO : kts_pkg::S_SRCH;
            end
            kts_pkg::S_SRCH: begin
                n_state = i_status.search_more ? kts_pkg::S_SRCH_WAIT : kts_pkg::S_RD_PL;
            end
            kts_pkg::S_SRCH_WAIT: n_state = kts_pkg::S_SRCH;
            kts_pkg::S_RD_PL:     n_state = kts_pkg::S_RD_PH;
            kts_pkg::S_RD_PH:     n_state = kts_pkg::S_WIDTH;
            kts_pkg::S_WIDTH: begin
                n_cnt   = '0;
                n_state = i_status.zero_width ? kts_pkg::S_VRD_LO : kts_pkg::S_FDIV;
            end
            kts_pkg::S_FDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == kts_pkg::F_DIV_LAST) begin
                    n_state = kts_pkg::S_F_DONE;
                end
            end
            kts_pkg::S_F_DONE: n_state = kts_pkg::S_VRD_LO;
            kts_pkg::S_VRD_LO: n_state = kts_pkg::S_VRD_HI;
            kts_pkg::S_VRD_HI: n_state = kts_pkg::S_VCAP;
            kts_pkg::S_VCAP: begin
                n_comp  = '0;
                n_state = kts_pkg::S_MUL;
            end
            kts_pkg::S_MUL: n_state = kts_pkg::S_ADD;
            kts_pkg::S_ADD: begin
                if (r_comp == last_comp) begin
                    n_state = i_status.value_kind ? kts_pkg::S_MAG : kts_pkg::S_OUT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = kts_pkg::S_MUL;
                end
            end
            kts_pkg::S_MAG: begin
                n_state = i_status.mag_zero ? kts_pkg::S_OUT : kts_pkg::S_SHIFT;
            end
            kts_pkg::S_SHIFT: begin
                if (i_status.mag_norm) begin
                    n_comp  = '0;
                    n_state = kts_pkg::S_SQ;
                end
            end
            kts_pkg::S_SQ: n_state = kts_pkg::S_ACC;
            kts_pkg::S_ACC: begin
                if (r_comp == kts_pkg::COMP_W) begin
                    n_state = kts_pkg::S_SQRT_INIT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = kts_pkg::S_SQ;
                end
            end
            kts_pkg::S_SQRT_INIT: begin
                n_cnt   = '0;
                n_state = kts_pkg::S_SQRT;
            end
            kts_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == kts_pkg::SQRT_LAST) begin
                    n_comp  = '0;
                    n_state = kts_pkg::S_NDIV_LOAD;
                end
            end
            kts_pkg::S_NDIV_LOAD: begin
                n_cnt   = '0;
                n_state = kts_pkg::S_NDIV;
            end
            kts_pkg::S_NDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == kts_pkg::ITER_W'(VALUE_FRAC_BITS)) begin
                    n_state = kts_pkg::S_NDIV_DONE;
                end
            end
            kts_pkg::S_NDIV_DONE: begin
                if (r_comp == kts_pkg::COMP_W) begin
                    n_state = kts_pkg::S_OUT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = kts_pkg::S_NDIV_LOAD;
                end
            end
            kts_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = kts_pkg::S_IDLE;
                end
            end
            default: n_state = kts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.comp = r_comp;
        o_cmd.op   = kts_pkg::OP_NONE;
        case (r_state)
            kts_pkg::S_IDLE:      o_cmd.op = i_in_valid ? kts_pkg::OP_ACCEPT : kts_pkg::OP_NONE;
            kts_pkg::S_RD_FIRST:  o_cmd.op = kts_pkg::OP_RD_FIRST;
            kts_pkg::S_RD_LAST:   o_cmd.op = kts_pkg::OP_RD_LAST;
            kts_pkg::S_CLASSIFY:  o_cmd.op = kts_pkg::OP_CLASSIFY;
            kts_pkg::S_SRCH: begin
                o_cmd.op = i_status.search_more ? kts_pkg::OP_SRCH_RD : kts_pkg::OP_NONE;
            end
            kts_pkg::S_SRCH_WAIT: o_cmd.op = kts_pkg::OP_SRCH_UPD;
            kts_pkg::S_RD_PL:     o_cmd.op = kts_pkg::OP_RD_PL;
            kts_pkg::S_RD_PH:     o_cmd.op = kts_pkg::OP_RD_PH;
            kts_pkg::S_WIDTH:     o_cmd.op = kts_pkg::OP_WIDTH;
            kts_pkg::S_FDIV:      o_cmd.op = kts_pkg::OP_DIV_STEP;
            kts_pkg::S_F_DONE:    o_cmd.op = kts_pkg::OP_F_DONE;
            kts_pkg::S_VRD_LO:    o_cmd.op = kts_pkg::OP_VRD_LO;
            kts_pkg::S_VRD_HI:    o_cmd.op = kts_pkg::OP_VRD_HI;
            kts_pkg::S_VCAP:      o_cmd.op = kts_pkg::OP_VCAP;
            kts_pkg::S_MUL:       o_cmd.op = kts_pkg::OP_MUL;
            kts_pkg::S_ADD:       o_cmd.op = kts_pkg::OP_ADD;
            kts_pkg::S_MAG:       o_cmd.op = kts_pkg::OP_MAG;
            kts_pkg::S_SHIFT:     o_cmd.op = kts_pkg::OP_SHIFT;
            kts_pkg::S_SQ:        o_cmd.op = kts_pkg::OP_SQ;
            kts_pkg::S_ACC:       o_cmd.op = kts_pkg::OP_ACC;
            kts_pkg::S_SQRT_INIT: o_cmd.op = kts_pkg::OP_SQRT_INIT;
            kts_pkg::S_SQRT:      o_cmd.op = kts_pkg::OP_SQRT_STEP;
            kts_pkg::S_NDIV_LOAD: o_cmd.op = kts_pkg::OP_NDIV_LOAD;
            kts_pkg::S_NDIV:      o_cmd.op = kts_pkg::OP_DIV_STEP;
            kts_pkg::S_NDIV_DONE: o_cmd.op = kts_pkg::OP_NDIV_DONE;
            kts_pkg::S_OUT:       o_cmd.op = out_free ? kts_pkg::OP_OUT : kts_pkg::OP_NONE;
            default:              o_cmd.op = kts_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kts_pkg::S_IDLE;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
            if (o_cmd.op == kts_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == kts_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ===== design/kts_datapath.sv =====
// Keyframe tables, search registers, shared divider, multiplier and square root.
// Depends on kts_pkg and kts_ram.
module kts_datapath #(
    parameter int MAX_KEYS        = 64,
    parameter int VALUE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  kts_pkg::t_dp_cmd    i_cmd,
    input  kts_pkg::t_in_item   i_in_data,
    input  logic [6:0]          i_keyframe_count,
    input  logic                i_value_kind,
    output kts_pkg::t_dp_status o_status,
    output kts_pkg::t_out_item  o_out_data
);
    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW  = $clog2(MAX_KEYS + 1);
    localparam int DVW = 31 + VALUE_FRAC_BITS;
    localparam int QW  = (VALUE_FRAC_BITS + 1 > 17) ? VALUE_FRAC_BITS + 1 : 17;

    function automatic logic [16:0] sat_pct(input logic [16:0] p);
        return (p > kts_pkg::PCT_ONE) ? kts_pkg::PCT_ONE : p;
    endfunction

    logic [16:0]        r_q, r_p0, r_pl, r_f;
    logic [NW-1:0]      r_n;
    logic [AW-1:0]      r_lo, r_hi, r_mid;
    logic [1:0]         r_st;
    logic signed [31:0] r_a [4];
    logic signed [31:0] r_b [4];
    logic signed [31:0] r_c [4];
    logic [31:0]        r_mag [4];
    logic signed [50:0] r_prod;
    logic [59:0]        r_sq;
    logic [61:0]        r_sum;
    logic [62:0]        r_v, r_res, r_bit;
    logic [32:0]        r_rem;
    logic [DVW-1:0]     r_low;
    logic [31:0]        r_div;
    logic [QW-1:0]      r_quo;
    kts_pkg::t_out_item r_out;

    logic               pct_we, pct_re, val_re;
    logic [AW-1:0]      waddr, pct_raddr, val_raddr;
    logic [16:0]        pct_rdata;
    logic [127:0]       val_rdata;
    logic signed [31:0] v_in [4];

    logic [AW:0]        lo_hi_sum;
    logic [AW-1:0]      mid, lo_p1, n_m1, n_m2;
    logic [16:0]        width, num_raw, num;
    logic [33:0]        div_t, div_d;
    logic               div_ge;
    logic [31:0]        m01, m23, m_max;
    logic [31:0]        abs_c [4];
    logic [DVW-1:0]     nd;
    logic signed [50:0] prod_rnd;
    logic [62:0]        sq_try;
    logic [31:0]        q_ext;
    logic [1:0]         k;

    assign k = i_cmd.comp;

    assign pct_we = (i_cmd.op == kts_pkg::OP_ACCEPT) &&
                    (i_in_data.mode == kts_pkg::MODE_LOAD) &&
                    (int'(i_in_data.key_index) < MAX_KEYS);
    assign waddr  = AW'(i_in_data.key_index);

    kts_ram #(.WIDTH(17), .DEPTH(MAX_KEYS)) u_pct_ram (
        .i_clk   (i_clk),
        .i_we    (pct_we),
        .i_waddr (waddr),
        .i_wdata (sat_pct(i_in_data.key_percent)),
        .i_re    (pct_re),
        .i_raddr (pct_raddr),
        .o_rdata (pct_rdata)
    );

    kts_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (pct_we),
        .i_waddr (waddr),
        .i_wdata ({i_in_data.in_x, i_in_data.in_y, i_in_data.in_z, i_in_data.in_w}),
        .i_re    (val_re),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[AW:1];
    assign lo_p1     = r_lo + AW'(1);
    assign n_m1      = AW'(r_n - NW'(1));
    assign n_m2      = AW'(r_n - NW'(2));

    always_comb begin
        pct_re    = 1'b0;
        val_re    = 1'b0;
        pct_raddr = r_lo;
        val_raddr = r_lo;
        case (i_cmd.op)
            kts_pkg::OP_RD_FIRST: begin
                pct_re    = 1'b1;
                pct_raddr = '0;
            end
            kts_pkg::OP_RD_LAST: begin
                pct_re    = 1'b1;
                pct_raddr = n_m1;
            end
            kts_pkg::OP_SRCH_RD: begin
                pct_re    = 1'b1;
                pct_raddr = mid;
            end
            kts_pkg::OP_RD_PL: pct_re = 1'b1;
            kts_pkg::OP_RD_PH: begin
                pct_re    = 1'b1;
                pct_raddr = lo_p1;
            end
            kts_pkg::OP_VRD_LO: val_re = 1'b1;
            kts_pkg::OP_VRD_HI: begin
                val_re    = 1'b1;
                val_raddr = lo_p1;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            v_in[i]  = val_rdata[32*(3-i) +: 32];
            abs_c[i] = r_c[i][31] ? (32'd0 - r_c[i]) : r_c[i];
        end
    end

    assign width   = pct_rdata - r_pl;
    assign num_raw = (r_q > r_pl) ? (r_q - r_pl) : 17'd0;
    assign num     = (num_raw > width) ? width : num_raw;

    assign div_t  = {r_rem, r_low[DVW-1]};
    assign div_d  = div_t - {2'b00, r_div};
    assign div_ge = (div_t >= {2'b00, r_div});

    assign m01   = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign m23   = (r_mag[2] > r_mag[3]) ? r_mag[2] : r_mag[3];
    assign m_max = (m01 > m23) ? m01 : m23;

    assign nd       = DVW'({r_mag[k][29:0], {VALUE_FRAC_BITS{1'b0}}}) + DVW'(r_res[31:1]);
    assign prod_rnd = (r_prod + 51'sd32768) >>> 16;
    assign sq_try   = r_res + r_bit;
    assign q_ext    = 32'(r_quo);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            kts_pkg::OP_ACCEPT: begin
                r_q  <= sat_pct(i_in_data.query_percent);
                r_lo <= '0;
                r_st <= kts_pkg::ST_LOAD;
                for (int i = 0; i < 4; i++) begin
                    r_c[i] <= '0;
                end
                if (i_keyframe_count < 7'd2) begin
                    r_n <= NW'(2);
                end else if (int'(i_keyframe_count) > MAX_KEYS) begin
                    r_n <= NW'(MAX_KEYS);
                end else begin
                    r_n <= NW'(i_keyframe_count);
                end
            end
            kts_pkg::OP_RD_LAST: r_p0 <= pct_rdata;
            kts_pkg::OP_CLASSIFY: begin
                r_hi <= n_m1;
                if (r_q < r_p0) begin
                    r_lo <= '0;
                    r_f  <= '0;
                    r_st <= kts_pkg::ST_CLAMP;
                end else if (r_q > pct_rdata) begin
                    r_lo <= n_m2;
                    r_f  <= kts_pkg::PCT_ONE;
                    r_st <= kts_pkg::ST_CLAMP;
                end else begin
                    r_lo <= '0;
                end
            end
            kts_pkg::OP_SRCH_RD: r_mid <= mid;
            kts_pkg::OP_SRCH_UPD: begin
                if (pct_rdata <= r_q) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid;
                end
            end
            kts_pkg::OP_RD_PH: r_pl <= pct_rdata;
            kts_pkg::OP_WIDTH: begin
                r_f   <= '0;
                r_st  <= kts_pkg::ST_ZERO_W;
                r_rem <= 33'(num >> 1);
                r_low <= DVW'({num[0], 16'd0}) << (DVW - 17);
                r_div <= 32'(width);
                r_quo <= '0;
            end
            kts_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? div_d[32:0] : div_t[32:0];
                r_low <= r_low << 1;
                r_quo <= {r_quo[QW-2:0], div_ge};
            end
            kts_pkg::OP_F_DONE: begin
                r_f  <= r_quo[16:0];
                r_st <= kts_pkg::ST_OK;
            end
            kts_pkg::OP_VRD_HI: begin
                for (int i = 0; i < 4; i++) begin
                    r_a[i] <= v_in[i];
                end
            end
            kts_pkg::OP_VCAP: begin
                for (int i = 0; i < 4; i++) begin
                    r_b[i] <= v_in[i];
                end
            end
            kts_pkg::OP_MUL: begin
                r_prod <= ($signed({r_b[k][31], r_b[k]}) - $signed({r_a[k][31], r_a[k]}))
                          * $signed({1'b0, r_f});
            end
            kts_pkg::OP_ADD: r_c[k] <= r_a[k] + prod_rnd[31:0];
            kts_pkg::OP_MAG: begin
                r_sum <= '0;
                for (int i = 0; i < 4; i++) begin
                    r_mag[i] <= abs_c[i];
                end
            end
            kts_pkg::OP_SHIFT: begin
                for (int i = 0; i < 4; i++) begin
                    if (m_max[31:30] != 2'b00) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (!m_max[29]) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            kts_pkg::OP_SQ:  r_sq  <= r_mag[k][29:0] * r_mag[k][29:0];
            kts_pkg::OP_ACC: r_sum <= r_sum + 62'(r_sq);
            kts_pkg::OP_SQRT_INIT: begin
                r_v   <= 63'(r_sum);
                r_res <= '0;
                r_bit <= 63'(1) << 62;
            end
            kts_pkg::OP_SQRT_STEP: begin
                if (r_v >= sq_try) begin
                    r_v   <= r_v - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            kts_pkg::OP_NDIV_LOAD: begin
                r_rem <= 33'(nd >> (VALUE_FRAC_BITS + 1));
                r_low <= nd << (DVW - VALUE_FRAC_BITS - 1);
                r_div <= r_res[31:0];
                r_quo <= '0;
            end
            kts_pkg::OP_NDIV_DONE: r_c[k] <= r_c[k][31] ? (32'd0 - q_ext) : q_ext;
            kts_pkg::OP_OUT: begin
                r_out.out_x     <= r_c[0];
                r_out.out_y     <= r_c[1];
                r_out.out_z     <= r_c[2];
                r_out.out_w     <= r_c[3];
                r_out.lower_key <= 6'(r_lo);
                r_out.status    <= r_st;
            end
            default: ;
        endcase
    end

    assign o_status.value_kind  = i_value_kind;
    assign o_status.below_first = (r_q < r_p0);
    assign o_status.above_last  = (r_q > pct_rdata);
    assign o_status.search_more = ({1'b0, lo_p1} < {1'b0, r_hi});
    assign o_status.zero_width  = (pct_rdata <= r_pl);
    assign o_status.mag_zero    = ((abs_c[0] | abs_c[1] | abs_c[2] | abs_c[3]) == 32'd0);
    assign o_status.mag_norm    = (m_max[31:29] == 3'b001);
    assign o_out_data           = r_out;
endmodule

// ===== dv/keyframe_track_sampler_unit_test.sv =====
// Self-checking bench for keyframe_track_sampler_unit: directed rows, then random key tracks.
// Depends on kts_pkg and the keyframe_track_sampler_unit RTL.
module keyframe_track_sampler_unit_test;

    localparam int NKEYS = 64;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    kts_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    kts_pkg::t_out_item out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = kts_pkg::CFG_KEY_COUNT;
    logic [6:0]         cfg_data = '0;

    keyframe_track_sampler_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // track state as seen by the bench
    logic [16:0]  pct_tab [NKEYS];
    longint       val_tab [NKEYS][4];
    logic [6:0]   key_count_reg = 7'd2;
    logic         quat_mode = 1'b0;

    kts_pkg::t_out_item pending_results[$];
    int           errors = 0;
    int           items_sent = 0;
    int           samples_seen = 0;
    int           clamps_seen = 0;
    int           zero_w_seen = 0;
    int           quat_seen = 0;
    bit           calm = 1'b0;
    bit           hold_done = 1'b0;

    typedef struct {
        bit                 is_cfg;
        logic               reg_idx;
        logic [6:0]         reg_val;
        kts_pkg::t_in_item  item;
        bit                 typed;
        kts_pkg::t_out_item want;
    } t_row;
    t_row rows[$];

    function automatic logic [16:0] sat_percent(logic [16:0] p);
        return (p > kts_pkg::PCT_ONE) ? kts_pkg::PCT_ONE : p;
    endfunction

    function automatic longint lerp_comp(longint a, longint b, longint f);
        longint prod;
        prod = (b - a) * f + 32768;
        if (prod >= 0)
            return a + (prod >>> 16);
        return a - ((-prod + 65535) >>> 16);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected result for one item; loads update the track tables
    function automatic kts_pkg::t_out_item sample_track(kts_pkg::t_in_item it);
        kts_pkg::t_out_item r;
        int n, lo, hi, mid;
        longint f, pl, ph, q, num, wid;
        longint c[4];
        longint unsigned mag[4], m, sum, len, qq;
        r = '0;
        if (it.mode == kts_pkg::MODE_LOAD) begin
            pct_tab[it.key_index] = sat_percent(it.key_percent);
            val_tab[it.key_index][0] = longint'(it.in_x);
            val_tab[it.key_index][1] = longint'(it.in_y);
            val_tab[it.key_index][2] = longint'(it.in_z);
            val_tab[it.key_index][3] = longint'(it.in_w);
            r.status = kts_pkg::ST_LOAD;
            return r;
        end
        n = int'(key_count_reg);
        if (n < 2) n = 2;
        if (n > NKEYS) n = NKEYS;
        q = longint'(sat_percent(it.query_percent));
        if (q < longint'(pct_tab[0])) begin
            lo = 0; f = 0; r.status = kts_pkg::ST_CLAMP;
        end else if (q > longint'(pct_tab[n-1])) begin
            lo = n - 2; f = 65536; r.status = kts_pkg::ST_CLAMP;
        end else begin
            lo = 0;
            hi = n - 1;
            while (lo + 1 < hi) begin
                mid = (lo + hi) / 2;
                if (longint'(pct_tab[mid]) <= q) lo = mid;
                else hi = mid;
            end
            pl = longint'(pct_tab[lo]);
            ph = longint'(pct_tab[lo+1]);
            if (ph <= pl) begin
                f = 0; r.status = kts_pkg::ST_ZERO_W;
            end else begin
                wid = ph - pl;
                num = (q > pl) ? q - pl : 0;
                if (num > wid) num = wid;
                f = (num << 16) / wid;
                r.status = kts_pkg::ST_OK;
            end
        end
        for (int i = 0; i < 4; i++)
            c[i] = lerp_comp(val_tab[lo][i], val_tab[lo+1][i], f);
        if (!quat_mode) begin
            c[3] = 0;
        end else begin
            m = 64'd0;
            for (int i = 0; i < 4; i++) begin
                mag[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                for (int i = 0; i < 4; i++) c[i] = 0;
            end else begin
                while (m >= (64'd1 << 30)) begin
                    m = m >> 1;
                    for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
                end
                while (m < (64'd1 << 29)) begin
                    m = m << 1;
                    for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
                end
                sum = 64'd0;
                for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
                len = root_floor(sum);
                for (int i = 0; i < 4; i++) begin
                    qq = ((mag[i] << 16) + len / 2) / len;
                    c[i] = (c[i] < 0) ? -longint'(qq) : longint'(qq);
                end
            end
        end
        r.out_x = c[0][31:0];
        r.out_y = c[1][31:0];
        r.out_z = c[2][31:0];
        r.out_w = c[3][31:0];
        r.lower_key = lo[5:0];
        return r;
    endfunction

    function automatic kts_pkg::t_in_item key_item(int idx, int pct, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z,
                                                   logic [31:0] w);
        kts_pkg::t_in_item it;
        it = '0;
        it.mode = kts_pkg::MODE_LOAD;
        it.key_index = idx[5:0];
        it.key_percent = pct[16:0];
        it.query_percent = 17'($urandom_range(0, 131071));
        it.in_x = x; it.in_y = y; it.in_z = z; it.in_w = w;
        return it;
    endfunction

    function automatic kts_pkg::t_in_item query_item(int pct);
        kts_pkg::t_in_item it;
        it = '0;
        it.mode = kts_pkg::MODE_SAMPLE;
        it.key_index = 6'($urandom_range(0, 63));
        it.key_percent = 17'($urandom_range(0, 131071));
        it.query_percent = pct[16:0];
        it.in_x = $urandom; it.in_y = $urandom; it.in_z = $urandom; it.in_w = $urandom;
        return it;
    endfunction

    function automatic kts_pkg::t_out_item vec_result(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z, logic [31:0] w,
                                                      int lo, logic [1:0] st);
        kts_pkg::t_out_item r;
        r.out_x = x; r.out_y = y; r.out_z = z; r.out_w = w;
        r.lower_key = lo[5:0];
        r.status = st;
        return r;
    endfunction

    task automatic add_item(kts_pkg::t_in_item it, bit typed = 1'b0,
                            kts_pkg::t_out_item want = '0);
        t_row rw;
        rw.is_cfg = 1'b0; rw.reg_idx = kts_pkg::CFG_KEY_COUNT; rw.reg_val = '0;
        rw.item = it; rw.typed = typed; rw.want = want;
        rows.push_back(rw);
    endtask

    task automatic add_cfg(logic idx, logic [6:0] val);
        t_row rw;
        rw.is_cfg = 1'b1; rw.reg_idx = idx; rw.reg_val = val;
        rw.item = '0; rw.typed = 1'b0; rw.want = '0;
        rows.push_back(rw);
    endtask

    task automatic send_item(kts_pkg::t_in_item it, bit typed, kts_pkg::t_out_item want);
        kts_pkg::t_out_item pred;
        if (in_valid && !calm && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        pred = sample_track(it);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        if (in_valid) in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == kts_pkg::CFG_KEY_COUNT) key_count_reg = val;
        else quat_mode = val[0];
    endtask

    // result checker
    always @(posedge clk) begin
        kts_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
                    out_data.out_z !== want.out_z || out_data.out_w !== want.out_w ||
                    out_data.lower_key !== want.lower_key ||
                    out_data.status !== want.status) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
                    errors++;
                end
                if (want.status != kts_pkg::ST_LOAD) samples_seen++;
                if (want.status == kts_pkg::ST_CLAMP) clamps_seen++;
                if (want.status == kts_pkg::ST_ZERO_W) zero_w_seen++;
                if (want.status != kts_pkg::ST_LOAD && quat_mode) quat_seen++;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int hold;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                hold = 0;
                while (hold < 600) begin
                    @(posedge clk);
                    hold++;
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 7);
            @(posedge clk);
        end
    end

    initial begin
        #48000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int n, p, phases;
        int extremes[4];
        kts_pkg::t_in_item it;
        kts_pkg::t_out_item none;
        none = '0;
        extremes = '{2, 64, 127, 0};

        // directed rows
        add_item(key_item(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 1, '0);
        add_item(key_item(1, 65536, 32'h7FFF_FFFF, 32'h8000_0000, 100, 5), 1, '0);
        add_item(query_item(0), 1,
                 vec_result(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, kts_pkg::ST_OK));
        add_item(query_item(65536), 1,
                 vec_result(32'h7FFF_FFFF, 32'h8000_0000, 100, 0, 0, kts_pkg::ST_OK));
        add_item(query_item(131071), 1,
                 vec_result(32'h7FFF_FFFF, 32'h8000_0000, 100, 0, 0, kts_pkg::ST_OK));
        add_item(query_item(32768));
        add_item(key_item(0, 1000, 7, -7, 32'hFFFF_FFFF, 1), 1, '0);
        add_item(query_item(0), 1,
                 vec_result(7, -7, 32'hFFFF_FFFF, 0, 0, kts_pkg::ST_CLAMP));
        add_item(key_item(1, 131071, 1, 2, 3, 4), 1, '0);
        add_item(key_item(2, 70000, 9, 9, 9, 9), 1, '0);
        add_cfg(kts_pkg::CFG_KEY_COUNT, 7'd3);
        add_item(query_item(40000));
        add_item(key_item(1, 500, 11, 12, 13, 14), 1, '0);
        add_item(query_item(1000));
        add_item(query_item(65536));
        add_cfg(kts_pkg::CFG_KEY_COUNT, 7'd0);
        add_item(query_item(2000));
        add_cfg(kts_pkg::CFG_VALUE_KIND, 7'd1);
        add_item(key_item(0, 0, 0, 0, 0, 65536), 1, '0);
        add_item(key_item(1, 65536, 0, 0, 0, 65536), 1, '0);
        add_item(query_item(30000), 1, vec_result(0, 0, 0, 65536, 0, kts_pkg::ST_OK));
        add_item(key_item(0, 0, 0, 0, 0, 0), 1, '0);
        add_item(key_item(1, 0, 0, 0, 0, 0), 1, '0);
        add_item(query_item(0), 1, vec_result(0, 0, 0, 0, 0, kts_pkg::ST_ZERO_W));
        add_item(key_item(63, 65536, 32'h8000_0000, 1, -1, 32'h7FFF_FFFF), 1, '0);
        add_cfg(kts_pkg::CFG_VALUE_KIND, 7'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
            else send_item(rows[i].item, rows[i].typed, rows[i].want);
        end

        // fill every slot so any count reads only written keys
        for (int k = 0; k < NKEYS; k++)
            send_item(key_item(k, k * 1024, $urandom, $urandom, $urandom, $urandom), 0, none);

        phases = 0;
        while (items_sent < 1450) begin
            n = (phases < 4) ? extremes[phases] : int'($urandom_range(2, 24));
            write_reg(kts_pkg::CFG_KEY_COUNT, n[6:0]);
            write_reg(kts_pkg::CFG_VALUE_KIND, 7'($urandom_range(0, 1)));
            if (n < 2) n = 2;
            if (n > NKEYS) n = NKEYS;
            calm = (items_sent >= 700 && items_sent < 900);
            p = $urandom_range(0, 4000);
            for (int k = 0; k < n; k++) begin
                it = key_item(k, p, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    it.in_x = $signed($urandom_range(0, 131072)) - 65536;
                    it.in_y = $signed($urandom_range(0, 131072)) - 65536;
                end
                if ($urandom_range(0, 15) == 0)
                    it.key_percent = 17'($urandom_range(0, 131071));
                send_item(it, 0, none);
                p = p + $urandom_range(0, 2 * 65536 / n);
                if (p > 65536) p = 65536;
            end
            repeat (40) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(key_item($urandom_range(0, 63), $urandom_range(0, 131071),
                                       $urandom, $urandom, $urandom, $urandom), 0, none);
                else if ($urandom_range(0, 4) == 0)
                    send_item(query_item($urandom_range(0, 131071)), 0, none);
                else
                    send_item(query_item($urandom_range(0, 65536)), 0, none);
            end
            phases++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);

        $display("%0d items, %0d samples (%0d quaternion), %0d clamped, %0d zero-width",
                 items_sent, samples_seen, quat_seen, clamps_seen, zero_w_seen);
        $display("%0d key-count settings from 0 to 127, both value kinds", phases + 2);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== keyframe_track_sampler_unit.f =====
+incdir+design
design/kts_pkg.sv
design/kts_ram.sv
design/kts_ctrl.sv
design/kts_datapath.sv
design/keyframe_track_sampler_unit.sv
dv/keyframe_track_sampler_unit_test.sv
